// ----- rtl/qvr_pkg.sv -----
// ----------------------------------------------------------------------------
// qvr_pkg
// types and constants shared by the quaternion vector rotation block
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam logic [1:0] MODE_ROT     = 2'd0;
  localparam logic [1:0] MODE_INV_ROT = 2'd1;
  localparam logic [1:0] MODE_INERTIA = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  localparam int QW  = 16;  // quaternion component width
  localparam int VW  = 32;  // vector component width
  localparam int IW  = 31;  // inertia width
  localparam int TW  = 52;  // first-product component width after shift (headroom)
  localparam int PW  = 72;  // product sum width

  typedef struct packed {
    logic [1:0]           mode;
    logic signed [QW-1:0] quat_w;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_z;
    logic signed [VW-1:0] vec_x;
    logic signed [VW-1:0] vec_y;
    logic signed [VW-1:0] vec_z;
    logic [IW-1:0]        inertia_x;
    logic [IW-1:0]        inertia_y;
    logic [IW-1:0]        inertia_z;
  } qvr_in_t;

  typedef struct packed {
    logic signed [VW-1:0] out_x;
    logic signed [VW-1:0] out_y;
    logic signed [VW-1:0] out_z;
    logic                 saturated;
  } qvr_out_t;

  function automatic logic signed [VW-1:0] sat32(input logic signed [PW-1:0] v,
                                                  output logic clip);
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
    begin
      hi = PW'(64'sh7FFF_FFFF);
      lo = -PW'(64'sh8000_0000);
      clip = 1'b0;
      if (v > hi) begin
        clip = 1'b1;
        sat32 = 32'sh7FFF_FFFF;
      end else if (v < lo) begin
        clip = 1'b1;
        sat32 = 32'sh8000_0000;
      end else begin
        sat32 = v[VW-1:0];
      end
    end
  endfunction

endpackage

// ----- rtl/qvr_if.sv -----
// ----------------------------------------------------------------------------
// qvr_in_if / qvr_out_if
// valid/ready channels carrying the rotation item and its result
// ----------------------------------------------------------------------------
interface qvr_in_if;
  logic             valid;
  logic             ready;
  qvr_pkg::qvr_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qvr_out_if;
  logic              valid;
  logic              ready;
  qvr_pkg::qvr_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/qvr_sandwich.sv -----
// ----------------------------------------------------------------------------
// qvr_sandwich
// pipelined quaternion sandwich product, four register stages
// ----------------------------------------------------------------------------
module qvr_sandwich #(
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic                              inverse,
  input  logic signed [qvr_pkg::QW-1:0]     q [4],
  input  logic signed [qvr_pkg::VW-1:0]     v [3],
  output logic                              out_valid,
  output logic signed [qvr_pkg::VW-1:0]     o [3],
  output logic                              clip
);
  localparam int PW = qvr_pkg::PW;
  localparam int TW = qvr_pkg::TW;

  // stage 1: first product terms (a*b), quaternion p = (0, v)
  // conjugate parts need one extra bit so that negating -1.0 stays exact
  logic signed [qvr_pkg::QW:0]   a1 [4];
  logic signed [qvr_pkg::QW-1:0] s1q [4];
  logic signed [PW-1:0]          m1 [12];
  logic                          s1v, s1inv;
  // stage 2: first product shifted
  logic signed [TW-1:0]          t2 [4];
  logic signed [qvr_pkg::QW-1:0] s2q [4];
  logic                          s2v, s2inv;
  // stage 3: second product terms
  logic signed [PW-1:0]          m3 [12];
  logic                          s3v;
  // stage 4: shifted, saturated
  logic                          s4v;

  always_comb begin
    // inverse: a = conj(q), second operand b = q; else a = q, b = conj(q)
    a1[0] = q[0];
    for (int i = 1; i < 4; i++) a1[i] = inverse ? -q[i] : q[i];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // a*p with p0 = 0
      m1[0]  <= PW'(a1[1]) * PW'(v[0]);
      m1[1]  <= PW'(a1[2]) * PW'(v[1]);
      m1[2]  <= PW'(a1[3]) * PW'(v[2]);
      m1[3]  <= PW'(a1[0]) * PW'(v[0]);
      m1[4]  <= PW'(a1[2]) * PW'(v[2]);
      m1[5]  <= PW'(a1[3]) * PW'(v[1]);
      m1[6]  <= PW'(a1[0]) * PW'(v[1]);
      m1[7]  <= PW'(a1[1]) * PW'(v[2]);
      m1[8]  <= PW'(a1[3]) * PW'(v[0]);
      m1[9]  <= PW'(a1[0]) * PW'(v[2]);
      m1[10] <= PW'(a1[1]) * PW'(v[1]);
      m1[11] <= PW'(a1[2]) * PW'(v[0]);
      for (int i = 0; i < 4; i++) s1q[i] <= q[i];
      s1inv <= inverse;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2[0] <= TW'((-m1[0] - m1[1] - m1[2]) >>> QUAT_FRAC_BITS);
      t2[1] <= TW'((m1[3] + m1[4] - m1[5]) >>> QUAT_FRAC_BITS);
      t2[2] <= TW'((m1[6] - m1[7] + m1[8]) >>> QUAT_FRAC_BITS);
      t2[3] <= TW'((m1[9] + m1[10] - m1[11]) >>> QUAT_FRAC_BITS);
      for (int i = 0; i < 4; i++) s2q[i] <= s1q[i];
      s2inv <= s1inv;
    end
  end

  logic signed [qvr_pkg::QW:0] b3 [4];
  always_comb begin
    b3[0] = s2q[0];
    for (int i = 1; i < 4; i++) b3[i] = s2inv ? s2q[i] : -s2q[i];
  end

  // t*b, x y z parts only
  always_ff @(posedge clk) begin
    if (en) begin
      m3[0]  <= PW'(t2[0]) * PW'(b3[1]);
      m3[1]  <= PW'(t2[1]) * PW'(b3[0]);
      m3[2]  <= PW'(t2[2]) * PW'(b3[3]);
      m3[3]  <= PW'(t2[3]) * PW'(b3[2]);
      m3[4]  <= PW'(t2[0]) * PW'(b3[2]);
      m3[5]  <= PW'(t2[1]) * PW'(b3[3]);
      m3[6]  <= PW'(t2[2]) * PW'(b3[0]);
      m3[7]  <= PW'(t2[3]) * PW'(b3[1]);
      m3[8]  <= PW'(t2[0]) * PW'(b3[3]);
      m3[9]  <= PW'(t2[1]) * PW'(b3[2]);
      m3[10] <= PW'(t2[2]) * PW'(b3[1]);
      m3[11] <= PW'(t2[3]) * PW'(b3[0]);
    end
  end

  logic signed [PW-1:0] r4 [3];
  logic [2:0]           c4;
  logic signed [qvr_pkg::VW-1:0] o4 [3];
  always_comb begin
    r4[0] = (m3[0] + m3[1] + m3[2] - m3[3]) >>> QUAT_FRAC_BITS;
    r4[1] = (m3[4] - m3[5] + m3[6] + m3[7]) >>> QUAT_FRAC_BITS;
    r4[2] = (m3[8] + m3[9] - m3[10] + m3[11]) >>> QUAT_FRAC_BITS;
    for (int i = 0; i < 3; i++) o4[i] = qvr_pkg::sat32(r4[i], c4[i]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) o[i] <= o4[i];
      clip <= |c4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
      s2v <= 1'b0;
      s3v <= 1'b0;
      s4v <= 1'b0;
    end else if (en) begin
      s1v <= in_valid;
      s2v <= s1v;
      s3v <= s2v;
      s4v <= s3v;
    end
  end

  assign out_valid = s4v;

endmodule

// ----- rtl/quaternion_vector_rotation_top.sv -----
// ----------------------------------------------------------------------------
// quaternion_vector_rotation_top
// quaternion sandwich rotation with optional inverse inertia scaling
// ----------------------------------------------------------------------------
// pipeline: eleven register stages in every mode
//   (4 first pass, 2 scaling, 4 second, 1 out)
// throughput: one beat per cycle unless the output stalls; the whole pipeline advances together
// stalls: a low ready downstream freezes every stage, nothing lost or repeated
// reset: synchronous, clears stage valid bits only; payload is not reset
module quaternion_vector_rotation_top #(
  parameter int QUAT_FRAC_BITS = 14,
  parameter int VEC_FRAC_BITS  = 16
) (
  input logic clk,
  input logic rst,
  qvr_in_if.sink    in_ch,
  qvr_out_if.source out_ch
);
  localparam int PW = qvr_pkg::PW;
  localparam int VW = qvr_pkg::VW;

  // pipeline advances when the output register is empty or being drained
  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  qvr_pkg::qvr_in_t d;
  assign d = in_ch.data;

  logic signed [qvr_pkg::QW-1:0] q [4];
  assign q[0] = d.quat_w;
  assign q[1] = d.quat_x;
  assign q[2] = d.quat_y;
  assign q[3] = d.quat_z;

  // first pass: inverse rotation for modes 1, 2 and 3, forward for mode 0
  logic signed [VW-1:0] v [3];
  assign v[0] = d.vec_x;
  assign v[1] = d.vec_y;
  assign v[2] = d.vec_z;

  logic                 a_valid, a_clip;
  logic signed [VW-1:0] a_o [3];
  qvr_sandwich #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_first (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(in_ch.valid && in_ch.ready),
    .inverse(d.mode != qvr_pkg::MODE_ROT),
    .q(q), .v(v),
    .out_valid(a_valid), .o(a_o), .clip(a_clip)
  );

  // side delay line for quaternion, inertia and mode across the first pass
  localparam int SD = 4;
  qvr_pkg::qvr_in_t side [SD];
  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= d;
      for (int i = 1; i < SD; i++) side[i] <= side[i-1];
    end
  end
  qvr_pkg::qvr_in_t sa;
  assign sa = side[SD-1];

  // inertia scaling: multiply stage, then shift and saturate stage
  logic signed [PW-1:0] im [3];
  always_ff @(posedge clk) begin
    if (en) begin
      im[0] <= PW'(a_o[0]) * PW'({1'b0, sa.inertia_x});
      im[1] <= PW'(a_o[1]) * PW'({1'b0, sa.inertia_y});
      im[2] <= PW'(a_o[2]) * PW'({1'b0, sa.inertia_z});
    end
  end
  qvr_pkg::qvr_in_t sb, sc;
  logic             b_valid, b_clip, c_valid, c_clip;
  logic signed [VW-1:0] b_o [3];
  logic signed [VW-1:0] c_l [3];
  logic signed [VW-1:0] c_raw [3];
  logic [2:0]           isat;
  logic signed [VW-1:0] isv [3];
  always_comb begin
    for (int i = 0; i < 3; i++) isv[i] = qvr_pkg::sat32(im[i] >>> VEC_FRAC_BITS, isat[i]);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sb <= sa;
      b_o <= a_o;
      b_clip <= a_clip;
      sc <= sb;
      c_raw <= b_o;
      // scaling clips only count in mode 2
      c_clip <= b_clip || ((sb.mode == qvr_pkg::MODE_INERTIA) && (|isat));
      c_l <= isv;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  // second pass: forward rotation of the scaled local vector (used in mode 2)
  logic signed [qvr_pkg::QW-1:0] qc [4];
  assign qc[0] = sc.quat_w;
  assign qc[1] = sc.quat_x;
  assign qc[2] = sc.quat_y;
  assign qc[3] = sc.quat_z;

  logic                 e_valid, e_clip;
  logic signed [VW-1:0] e_o [3];
  qvr_sandwich #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_second (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(c_valid), .inverse(1'b0),
    .q(qc), .v(c_l),
    .out_valid(e_valid), .o(e_o), .clip(e_clip)
  );

  // carry first-pass result, clip flag and mode past the second pass
  logic [1:0]           dm [SD];
  logic                 dcl [SD];
  logic signed [VW-1:0] dr [SD][3];
  always_ff @(posedge clk) begin
    if (en) begin
      dm[0] <= sc.mode;
      dcl[0] <= c_clip;
      dr[0] <= c_raw;
      for (int i = 1; i < SD; i++) begin
        dm[i] <= dm[i-1];
        dcl[i] <= dcl[i-1];
        dr[i] <= dr[i-1];
      end
    end
  end

  // output register
  qvr_pkg::qvr_out_t res;
  always_comb begin
    res = '0;
    case (dm[SD-1])
      qvr_pkg::MODE_ROT, qvr_pkg::MODE_INV_ROT: begin
        res.out_x = dr[SD-1][0];
        res.out_y = dr[SD-1][1];
        res.out_z = dr[SD-1][2];
        res.saturated = dcl[SD-1];
      end
      qvr_pkg::MODE_INERTIA: begin
        res.out_x = e_o[0];
        res.out_y = e_o[1];
        res.out_z = e_o[2];
        res.saturated = dcl[SD-1] || e_clip;
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) out_ch.data <= res;
  end
  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (en) out_ch.valid <= e_valid;
  end

  // a stalled output must hold its beat
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("output beat changed under stall");
  // stages keep order: first pass valid feeds the inertia stage in the next cycle
  a_chain: assert property (@(posedge clk) disable iff (rst)
    en && a_valid |=> b_valid)
    else $error("valid lost between stages");
  // unused mode never flags saturation
  a_mode3: assert property (@(posedge clk) disable iff (rst)
    en && e_valid && dm[SD-1] == qvr_pkg::MODE_UNUSED |=> !out_ch.data.saturated)
    else $error("unused mode reported saturation");

endmodule
